### hdl/assert_macros.svh
// Assertion macros shared by the box filter RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BFM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bfm_pkg.sv
// Types and constants for the 3x3 box mean filter.
// No dependencies; imported by box_filter_3x3_mean_core.
`default_nettype none

package bfm_pkg;

  localparam int unsigned AVG_W      = 16;
  localparam int unsigned PIX_IN_W   = 16;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned DIM_RST    = 32;

  localparam int unsigned OQ_DEPTH   = 8;
  localparam int unsigned OQ_AW      = 3;
  localparam int unsigned OQ_CNT_W   = 4;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } bfm_reg_t;

  typedef struct packed {
    logic             has_res;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_end;
  } bfm_meta_t;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_end;
  } bfm_result_t;

endpackage

`default_nettype wire

### hdl/box_filter_3x3_mean_core.sv
// 3x3 box mean filter: line buffers in two synchronous memories, column sums and a
// reciprocal divider by nine. Depends on bfm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block takes one pixel per clock in raster order while in_stall is low and, for
// every interior pixel, returns the rounded mean of its 3x3 neighbourhood with the
// centre's row and column; border pixels give no result. A result passes the first
// stage, the column-sum, total and multiply registers and the output queue before it
// reaches the outputs. The two previous lines live in two simple dual-port memories
// (one read, one write a cycle), read on acceptance and written from the first stage,
// with forwarding when a pixel hits the column just written. Results pass through an
// eight-entry output queue, so out_stall never reaches in_stall combinationally;
// in_stall rises only when that queue, plus up to four requests still in the pipeline,
// could fill it. Registers may be written only while the filter is idle.
module box_filter_3x3_mean_core
  import bfm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [PIX_IN_W-1:0] in_pixel,
  input  wire logic                in_frame_start,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [AVG_W-1:0]         out_average,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic                     out_frame_end,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMPW      = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
  localparam int unsigned PW        = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;
  localparam int unsigned CSW       = PW + 2;
  localparam int unsigned SW        = PW + 4;
  localparam int unsigned DIV_SHIFT = SW + 4;
  localparam int unsigned MW        = DIV_SHIFT - 2;
  localparam int unsigned PRODW     = SW + MW;
  localparam int unsigned QW        = PRODW - DIV_SHIFT;
  localparam int unsigned WIDTH_RST = (MAX_WIDTH < DIM_RST) ? MAX_WIDTH : DIM_RST;
  localparam longint unsigned RECIP = ((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9;
  localparam logic [MW-1:0]   RECIP_V = MW'(RECIP);
  localparam int unsigned INFL_W    = OQ_CNT_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_raw_r;
  logic [DIM_W-1:0] height_raw_r;
  logic [AW-1:0]    w_last_r;
  logic [POS_W-1:0] h_last_r;
  logic             cfg_wr;
  logic [CMPW-1:0]  wv;
  logic [DIM_W-1:0] hv;
  logic [AW-1:0]    w_last_nxt;
  logic [POS_W-1:0] h_last_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign wv     = CMPW'(pwdata[DIM_W-1:0]);
  assign hv     = pwdata[DIM_W-1:0];

  // Out-of-range sizes saturate; the last column and row index are kept directly.
  always_comb begin
    if (wv < CMPW'(3)) begin
      w_last_nxt = AW'(2);
    end else if (wv > CMPW'(MAX_WIDTH)) begin
      w_last_nxt = AW'(MAX_WIDTH - 1);
    end else begin
      w_last_nxt = AW'(wv - CMPW'(1));
    end
    if (hv < DIM_W'(3)) begin
      h_last_nxt = POS_W'(2);
    end else if (hv > DIM_W'(MAX_HEIGHT)) begin
      h_last_nxt = POS_W'(MAX_HEIGHT - 1);
    end else begin
      h_last_nxt = POS_W'(hv - DIM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= DIM_W'(DIM_RST);
      height_raw_r <= DIM_W'(DIM_RST);
      w_last_r     <= AW'(WIDTH_RST - 1);
      h_last_r     <= POS_W'(DIM_RST - 1);
    end else if (cfg_wr) begin
      unique case (bfm_reg_t'(paddr[2]))
        REG_IMAGE_WIDTH: begin
          width_raw_r <= hv;
          w_last_r    <= w_last_nxt;
        end
        REG_IMAGE_HEIGHT: begin
          height_raw_r <= hv;
          h_last_r     <= h_last_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (bfm_reg_t'(paddr[2]))
      REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_raw_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DW'(height_raw_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Position tracking and request acceptance
  // ---------------------------------------------------------------------------
  logic [AW-1:0]     col_r, col_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [AW-1:0]     col0, c_sel;
  logic [POS_W-1:0]  row0, r_sel;
  logic              col_wrap;
  logic [POS_W:0]    r1;
  logic              in_acc;
  bfm_meta_t         meta0;

  assign in_acc = in_valid & ~in_stall;

  always_comb begin
    col0     = in_frame_start ? '0 : col_r;
    row0     = in_frame_start ? '0 : row_r;
    // A column left beyond a shrunken width moves to the start of the next line.
    col_wrap = col0 > w_last_r;
    c_sel    = col_wrap ? '0 : col0;
    r1       = {1'b0, row0} + (POS_W+1)'(col_wrap);
    r_sel    = (r1 > {1'b0, h_last_r}) ? '0 : r1[POS_W-1:0];

    if (c_sel == w_last_r) begin
      col_nxt = '0;
      row_nxt = (r_sel == h_last_r) ? '0 : r_sel + POS_W'(1);
    end else begin
      col_nxt = c_sel + AW'(1);
      row_nxt = r_sel;
    end

    meta0.has_res   = (r_sel >= POS_W'(2)) && (c_sel >= AW'(2));
    meta0.row       = r_sel - POS_W'(1);
    meta0.col       = POS_W'(c_sel - AW'(1));
    meta0.frame_end = (r_sel == h_last_r) && (c_sel == w_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer memories: read on acceptance, written back in the following cycle
  // ---------------------------------------------------------------------------
  logic [PW-1:0] upper_mem  [MAX_WIDTH];
  logic [PW-1:0] middle_mem [MAX_WIDTH];
  logic [PW-1:0] up_rd_r, mid_rd_r;

  logic          s1_valid_r;
  bfm_meta_t     s1_meta_r;
  logic [AW-1:0] s1_addr_r;
  logic [PW-1:0] s1_px_r;
  logic [PW-1:0] s1_up, s1_mid;
  logic          fwd_hit_r;
  logic [PW-1:0] fwd_up_r, fwd_mid_r;

  // A request right behind one at the same column reads the memory before the
  // write lands, so the written pair is forwarded instead.
  assign s1_up  = fwd_hit_r ? fwd_up_r  : up_rd_r;
  assign s1_mid = fwd_hit_r ? fwd_mid_r : mid_rd_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      upper_mem[s1_addr_r]  <= s1_mid;
      middle_mem[s1_addr_r] <= s1_px_r;
    end
    if (in_acc) begin
      up_rd_r  <= upper_mem[c_sel];
      mid_rd_r <= middle_mem[c_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        fwd_hit_r <= s1_valid_r && (s1_addr_r == c_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_meta_r <= meta0;
      s1_addr_r <= c_sel;
      s1_px_r   <= in_pixel[PW-1:0];
      fwd_up_r  <= s1_mid;
      fwd_mid_r <= s1_px_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Column sums, total, reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [CSW-1:0]   cs0_r, cs1_r, cs2_r;
  logic             sa_valid_r, sb_valid_r, sc_valid_r;
  bfm_meta_t        sa_meta_r, sb_meta_r, sc_meta_r;
  logic [SW-1:0]    sum_r;
  logic [PRODW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
      sb_valid_r <= 1'b0;
      sc_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= s1_valid_r;
      sb_valid_r <= sa_valid_r;
      sc_valid_r <= sb_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      cs0_r     <= cs1_r;
      cs1_r     <= cs2_r;
      cs2_r     <= CSW'(s1_up) + CSW'(s1_mid) + CSW'(s1_px_r);
      sa_meta_r <= s1_meta_r;
    end
    // The bias of four turns the truncating divide into round to nearest.
    sum_r     <= SW'(cs0_r) + SW'(cs1_r) + SW'(cs2_r) + SW'(4);
    sb_meta_r <= sa_meta_r;
    prod_r    <= {{MW{1'b0}}, sum_r} * {{SW{1'b0}}, RECIP_V};
    sc_meta_r <= sb_meta_r;
  end

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  bfm_result_t          oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]     oq_wp_r, oq_rp_r;
  logic [OQ_CNT_W-1:0]  oq_cnt_r;
  logic                 oq_wr, oq_rd;
  bfm_result_t          oq_din, oq_head;
  logic [INFL_W-1:0]    inflight;

  assign oq_wr = sc_valid_r & sc_meta_r.has_res;
  assign oq_rd = out_valid & ~out_stall;

  always_comb begin
    oq_din.average   = AVG_W'(prod_r[DIV_SHIFT +: QW]);
    oq_din.row       = sc_meta_r.row;
    oq_din.col       = sc_meta_r.col;
    oq_din.frame_end = sc_meta_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_mem[oq_wp_r] <= oq_din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_wr) begin
        oq_wp_r <= oq_wp_r + OQ_AW'(1);
      end
      if (oq_rd) begin
        oq_rp_r <= oq_rp_r + OQ_AW'(1);
      end
      case ({oq_wr, oq_rd})
        2'b10:   oq_cnt_r <= oq_cnt_r + OQ_CNT_W'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - OQ_CNT_W'(1);
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

  // Every request still in the pipeline may yet need a queue entry.
  assign inflight = INFL_W'(oq_cnt_r) + INFL_W'(s1_valid_r) + INFL_W'(sa_valid_r)
                  + INFL_W'(sb_valid_r) + INFL_W'(sc_valid_r);
  assign in_stall = inflight >= INFL_W'(OQ_DEPTH);

  assign oq_head       = oq_mem[oq_rp_r];
  assign out_valid     = oq_cnt_r != '0;
  assign out_average   = oq_head.average;
  assign out_row       = oq_head.row;
  assign out_col       = oq_head.col;
  assign out_frame_end = oq_head.frame_end;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BFM_ASSERT_IMPLIES(a_oq_no_overflow, oq_wr, (oq_cnt_r < OQ_CNT_W'(OQ_DEPTH)) || oq_rd, "output queue overflow")
  `BFM_ASSERT_NEXT(a_accept_enters_s1, in_acc, s1_valid_r, "accepted request missing from first stage")
  `BFM_ASSERT_IMPLIES(a_fwd_needs_item, fwd_hit_r && !s1_valid_r, !sa_valid_r || sb_valid_r, "forwarding flag without a request")
  `BFM_ASSERT_IMPLIES(a_result_interior, out_valid, (out_row != '0) && (out_col != '0), "result on a border position")

endmodule

`default_nettype wire
